// File: rtl/tas_pkg.sv
// Shared types, codes and constants of the threshold alarm block.
package tas_pkg;

  localparam int KEY_W       = 18;
  localparam int TIME_W      = 48;
  localparam int HOLD_W      = 32;
  localparam int VAL_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int DEF_ENTRIES = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // command codes
  localparam logic [1:0] CMD_CHECK    = 2'd0;
  localparam logic [1:0] CMD_SUPPRESS = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  // alarm kinds
  localparam logic [1:0] KIND_CAV   = 2'd0;
  localparam logic [1:0] KIND_VIB   = 2'd1;
  localparam logic [1:0] KIND_LIFE  = 2'd2;
  localparam logic [1:0] KIND_FAULT = 2'd3;

  // alarm levels
  localparam logic [1:0] LVL_WARNING   = 2'd0;
  localparam logic [1:0] LVL_CRITICAL  = 2'd1;
  localparam logic [1:0] LVL_EMERGENCY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAV_WARN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAV_CRIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_WARN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_CRIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DMG_LIM  = 3'd4;

  typedef struct packed {
    logic [VAL_W-1:0] cav_warn;
    logic [VAL_W-1:0] cav_crit;
    logic [VAL_W-1:0] vib_warn;
    logic [VAL_W-1:0] vib_crit;
    logic [VAL_W-1:0] dmg_lim;
  } tas_thr_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] expiry;
  } tas_entry_t;

  typedef struct packed {
    logic             alarm_raised;
    logic [1:0]       level;
    logic [1:0]       alarm_kind;
    logic [7:0]       alarm_unit;
    logic [7:0]       alarm_blade;
    logic [VAL_W-1:0] crossed_threshold;
    logic [VAL_W-1:0] measured_out;
    logic             was_suppressed;
    logic             table_full;
  } tas_result_t;

  function automatic logic [KEY_W-1:0] make_key(input logic [7:0] unit,
                                                input logic [7:0] blade,
                                                input logic [1:0] kind);
    return {unit, blade, kind};
  endfunction

endpackage

// File: rtl/threshold_alarm_with_suppression.sv
// Top level: configuration registers, sequencer and suppression table.
//
// Command channel: an item is taken at a rising edge where start is high and
// busy is low. cmd selects check (0), suppress (1) or a millisecond tick (2).
// Each item gives exactly one result, shown on the out_ ports for one cycle
// with out_strobe high; the receiver takes it at the edge ending that cycle
// and has no way to hold it off.
// Check and suppress scan the suppression table one entry a cycle through a
// single key/expiry comparator; the table read is registered. After the scan
// the sequencer passes a wait state and a done state, and the strobe is
// registered from the done state; no new item is taken until it is back idle.
// Tick and unknown commands skip the scan and go straight to the done state.
// busy is high from the accept edge until the result is issued.
// Configuration: cfg_we with cfg_index and cfg_data writes a threshold at the
// next edge; write only while no item is in flight. Unknown indexes are ignored.
// Reset (synchronous, rst_n low) sets all thresholds to 65535, clears the
// table's valid bits and the millisecond clock; no clearing pass is needed.
module threshold_alarm_with_suppression #(
  parameter int SUPPRESS_ENTRIES = tas_pkg::DEF_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [7:0]                    in_unit_id,
  input  logic [7:0]                    in_blade_no,
  input  logic [1:0]                    in_alarm_type,
  input  logic [tas_pkg::VAL_W-1:0]     in_sample_value,
  input  logic [tas_pkg::HOLD_W-1:0]    in_hold_ms,
  output logic                          out_strobe,
  output logic                          out_alarm_raised,
  output logic [1:0]                    out_alarm_level,
  output logic [1:0]                    out_alarm_kind,
  output logic [7:0]                    out_alarm_unit,
  output logic [7:0]                    out_alarm_blade,
  output logic [tas_pkg::VAL_W-1:0]     out_crossed_threshold,
  output logic [tas_pkg::VAL_W-1:0]     out_measured_out,
  output logic                          out_was_suppressed,
  output logic                          out_table_full,
  input  logic                          cfg_we,
  input  logic [tas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tas_pkg::VAL_W-1:0]     cfg_data
);

  localparam int IDX_W = (SUPPRESS_ENTRIES > 1) ? $clog2(SUPPRESS_ENTRIES) : 1;

  tas_pkg::tas_thr_t    thr_r;
  tas_pkg::tas_entry_t  rd_entry;
  tas_pkg::tas_entry_t  wr_entry;
  tas_pkg::tas_result_t res;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 rd_valid;
  logic                 wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.cav_warn <= '1;
      thr_r.cav_crit <= '1;
      thr_r.vib_warn <= '1;
      thr_r.vib_crit <= '1;
      thr_r.dmg_lim  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        tas_pkg::CFG_CAV_WARN: thr_r.cav_warn <= cfg_data;
        tas_pkg::CFG_CAV_CRIT: thr_r.cav_crit <= cfg_data;
        tas_pkg::CFG_VIB_WARN: thr_r.vib_warn <= cfg_data;
        tas_pkg::CFG_VIB_CRIT: thr_r.vib_crit <= cfg_data;
        tas_pkg::CFG_DMG_LIM:  thr_r.dmg_lim  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tas_ctrl #(
    .ENTRIES (SUPPRESS_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (in_cmd),
    .unit_id      (in_unit_id),
    .blade_no     (in_blade_no),
    .kind_code    (in_alarm_type),
    .sample_value (in_sample_value),
    .hold_ms      (in_hold_ms),
    .thr          (thr_r),
    .rd_addr      (rd_addr),
    .rd_valid     (rd_valid),
    .rd_entry     (rd_entry),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_entry     (wr_entry),
    .res          (res),
    .res_strobe   (out_strobe)
  );

  tas_table #(
    .ENTRIES (SUPPRESS_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  assign out_alarm_raised      = res.alarm_raised;
  assign out_alarm_level       = res.level;
  assign out_alarm_kind        = res.alarm_kind;
  assign out_alarm_unit        = res.alarm_unit;
  assign out_alarm_blade       = res.alarm_blade;
  assign out_crossed_threshold = res.crossed_threshold;
  assign out_measured_out      = res.measured_out;
  assign out_was_suppressed    = res.was_suppressed;
  assign out_table_full        = res.table_full;

endmodule

// File: rtl/tas_table.sv
// Suppression table: key/expiry memory with registered read and per-entry valid bits.
module tas_table #(
  parameter int ENTRIES = tas_pkg::DEF_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic                rd_valid,
  output tas_pkg::tas_entry_t rd_entry,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  tas_pkg::tas_entry_t wr_entry
);

  tas_pkg::tas_entry_t mem_r [ENTRIES];
  tas_pkg::tas_entry_t rd_entry_r;
  logic [ENTRIES-1:0]  valid_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    rd_entry_r <= mem_r[rd_addr];
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

endmodule

// File: rtl/tas_ctrl.sv
// Sequencer: scans the table through one shared key/expiry compare, then forms the result.
module tas_ctrl #(
  parameter int ENTRIES = tas_pkg::DEF_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [7:0]                 unit_id,
  input  logic [7:0]                 blade_no,
  input  logic [1:0]                 kind_code,
  input  logic [tas_pkg::VAL_W-1:0]  sample_value,
  input  logic [tas_pkg::HOLD_W-1:0] hold_ms,
  input  tas_pkg::tas_thr_t          thr,
  output logic [IDX_W-1:0]           rd_addr,
  input  logic                       rd_valid,
  input  tas_pkg::tas_entry_t        rd_entry,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_addr,
  output tas_pkg::tas_entry_t        wr_entry,
  output tas_pkg::tas_result_t       res,
  output logic                       res_strobe
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]                  state_r;
  logic [IDX_W-1:0]            addr_r;
  logic                        pend_r;
  logic [IDX_W-1:0]            pidx_r;
  logic [1:0]                  cmd_r;
  logic [7:0]                  unit_r;
  logic [7:0]                  blade_r;
  logic [1:0]                  kind_r;
  logic [tas_pkg::VAL_W-1:0]   val_r;
  logic [tas_pkg::HOLD_W-1:0]  hold_r;
  logic [tas_pkg::TIME_W-1:0]  now_r;
  logic                        hit_r;
  logic                        km_found_r;
  logic [IDX_W-1:0]            km_idx_r;
  logic                        fr_found_r;
  logic [IDX_W-1:0]            fr_idx_r;
  tas_pkg::tas_result_t        res_r;
  tas_pkg::tas_result_t        res_nxt;
  logic                        strobe_r;

  logic                        accept;
  logic                        done;
  logic [tas_pkg::KEY_W-1:0]   key;
  logic                        live;
  logic                        keq;
  logic [tas_pkg::TIME_W:0]    exp_sum;
  logic [tas_pkg::TIME_W-1:0]  exp_sat;
  logic                        slot_ok;
  logic [tas_pkg::VAL_W-1:0]   warn;
  logic [tas_pkg::VAL_W-1:0]   crit;

  assign accept = start && (state_r == ST_IDLE);
  assign done   = (state_r == ST_DONE);
  assign busy   = (state_r != ST_IDLE);

  assign key  = tas_pkg::make_key(unit_r, blade_r, kind_r);
  // shared compare unit: one entry per cycle
  assign live = rd_valid && (rd_entry.expiry > now_r);
  assign keq  = (rd_entry.key == key);

  assign exp_sum = {1'b0, now_r} + {{(tas_pkg::TIME_W + 1 - tas_pkg::HOLD_W){1'b0}}, hold_r};
  assign exp_sat = exp_sum[tas_pkg::TIME_W] ? tas_pkg::TIME_MAX
                                            : exp_sum[tas_pkg::TIME_W-1:0];

  // an entry with the same key wins over a free one
  assign slot_ok         = km_found_r || fr_found_r;
  assign rd_addr         = addr_r;
  assign wr_en           = done && (cmd_r == tas_pkg::CMD_SUPPRESS) && slot_ok;
  assign wr_addr         = km_found_r ? km_idx_r : fr_idx_r;
  assign wr_entry.key    = key;
  assign wr_entry.expiry = exp_sat;

  assign warn = (kind_r == tas_pkg::KIND_CAV) ? thr.cav_warn : thr.vib_warn;
  assign crit = (kind_r == tas_pkg::KIND_CAV) ? thr.cav_crit : thr.vib_crit;

  always_comb begin
    res_nxt = '0;
    case (cmd_r)
      tas_pkg::CMD_CHECK: begin
        res_nxt.alarm_kind   = kind_r;
        res_nxt.alarm_unit   = unit_r;
        res_nxt.alarm_blade  = blade_r;
        res_nxt.measured_out = val_r;
        if (hit_r) begin
          res_nxt.was_suppressed = 1'b1;
        end else begin
          case (kind_r)
            tas_pkg::KIND_CAV, tas_pkg::KIND_VIB: begin
              if (val_r >= warn) begin
                res_nxt.alarm_raised = 1'b1;
                if (val_r >= crit) begin
                  res_nxt.level             = tas_pkg::LVL_EMERGENCY;
                  res_nxt.crossed_threshold = crit;
                end else begin
                  res_nxt.level             = tas_pkg::LVL_CRITICAL;
                  res_nxt.crossed_threshold = warn;
                end
              end
            end
            tas_pkg::KIND_LIFE: begin
              if (val_r >= thr.dmg_lim) begin
                res_nxt.alarm_raised      = 1'b1;
                res_nxt.level             = tas_pkg::LVL_CRITICAL;
                res_nxt.crossed_threshold = thr.dmg_lim;
              end
            end
            default: begin
              // sensor fault never alarms
            end
          endcase
        end
      end
      tas_pkg::CMD_SUPPRESS: begin
        res_nxt.table_full = !slot_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      addr_r   <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      now_r    <= '0;
    end else begin
      pend_r   <= (state_r == ST_SCAN);
      strobe_r <= done;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            addr_r <= '0;
            if (cmd == tas_pkg::CMD_CHECK || cmd == tas_pkg::CMD_SUPPRESS) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (addr_r == LAST_IDX) begin
            state_r <= ST_WAIT;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        ST_WAIT: begin
          state_r <= ST_DONE;
        end
        default: begin
          state_r <= ST_IDLE;
          if (cmd_r == tas_pkg::CMD_TICK && now_r != tas_pkg::TIME_MAX) begin
            now_r <= now_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= addr_r;
    if (accept) begin
      cmd_r      <= cmd;
      unit_r     <= unit_id;
      blade_r    <= blade_no;
      kind_r     <= kind_code;
      val_r      <= sample_value;
      hold_r     <= hold_ms;
      hit_r      <= 1'b0;
      km_found_r <= 1'b0;
      fr_found_r <= 1'b0;
      km_idx_r   <= '0;
      fr_idx_r   <= '0;
    end else if (pend_r) begin
      if (live && keq) begin
        hit_r <= 1'b1;
      end
      if (!km_found_r && rd_valid && keq) begin
        km_found_r <= 1'b1;
        km_idx_r   <= pidx_r;
      end
      if (!fr_found_r && !live) begin
        fr_found_r <= 1'b1;
        fr_idx_r   <= pidx_r;
      end
    end
    if (done) begin
      res_r <= res_nxt;
    end
  end

  assign res        = res_r;
  assign res_strobe = strobe_r;

endmodule

// File: rtl/tas_checker.sv
// Port-level checks of the threshold alarm block, bound to the top level.
module tas_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input logic                      out_alarm_raised,
  input logic [1:0]                out_alarm_level,
  input logic [7:0]                out_alarm_unit,
  input logic [tas_pkg::VAL_W-1:0] out_crossed_threshold,
  input logic [tas_pkg::VAL_W-1:0] out_measured_out,
  input logic                      out_was_suppressed,
  input logic                      out_table_full
);

  // an accepted transaction keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // the result leaves with the block already free
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  // a raised alarm is never suppressed, never a warning, and lies at or above its threshold
  a_alarm_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_alarm_raised |->
      !out_was_suppressed && !out_table_full &&
      out_alarm_level != tas_pkg::LVL_WARNING &&
      out_measured_out >= out_crossed_threshold)
    else $error("inconsistent alarm result");

  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_table_full |->
      !out_was_suppressed && out_measured_out == '0 && out_alarm_unit == '0)
    else $error("table full result carries check fields");

endmodule

bind threshold_alarm_with_suppression tas_checker u_tas_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the threshold alarm block: directed table, then random commands.
module testbench;
  import tas_pkg::*;

  localparam int ENTRIES   = DEF_ENTRIES;
  localparam int LIMIT     = 300000;
  localparam int PHASES    = 6;
  localparam int PER_PHASE = 170;

  localparam logic [1:0]           CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    logic [1:0]        cmd;
    logic [7:0]        unit;
    logic [7:0]        blade;
    logic [1:0]        kind;
    logic [VAL_W-1:0]  val;
    logic [HOLD_W-1:0] hold;
  } cmd_t;

  typedef struct {
    row_kind_t            what;
    cmd_t                 c;
    logic [CFG_IDX_W-1:0] idx;
    logic [VAL_W-1:0]     data;
    bit                   has_exp;
    tas_result_t          exp;
  } row_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic [1:0]           in_cmd          = '0;
  logic [7:0]           in_unit_id      = '0;
  logic [7:0]           in_blade_no     = '0;
  logic [1:0]           in_alarm_type   = '0;
  logic [VAL_W-1:0]     in_sample_value = '0;
  logic [HOLD_W-1:0]    in_hold_ms      = '0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [VAL_W-1:0]     cfg_data        = '0;

  logic             busy;
  logic             out_strobe;
  logic             out_alarm_raised;
  logic [1:0]       out_alarm_level;
  logic [1:0]       out_alarm_kind;
  logic [7:0]       out_alarm_unit;
  logic [7:0]       out_alarm_blade;
  logic [VAL_W-1:0] out_crossed_threshold;
  logic [VAL_W-1:0] out_measured_out;
  logic             out_was_suppressed;
  logic             out_table_full;

  threshold_alarm_with_suppression dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_unit_id           (in_unit_id),
    .in_blade_no          (in_blade_no),
    .in_alarm_type        (in_alarm_type),
    .in_sample_value      (in_sample_value),
    .in_hold_ms           (in_hold_ms),
    .out_strobe           (out_strobe),
    .out_alarm_raised     (out_alarm_raised),
    .out_alarm_level      (out_alarm_level),
    .out_alarm_kind       (out_alarm_kind),
    .out_alarm_unit       (out_alarm_unit),
    .out_alarm_blade      (out_alarm_blade),
    .out_crossed_threshold(out_crossed_threshold),
    .out_measured_out     (out_measured_out),
    .out_was_suppressed   (out_was_suppressed),
    .out_table_full       (out_table_full),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #1 clk = ~clk;

  // alarm predictor state
  tas_thr_t          thr;
  logic              sup_valid  [ENTRIES];
  logic [KEY_W-1:0]  sup_key    [ENTRIES];
  logic [TIME_W-1:0] sup_expiry [ENTRIES];
  logic [TIME_W-1:0] ms_now;
  cmd_t              armed;

  tas_result_t alarms_due[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int n_items       = 0;
  int n_checks      = 0;
  int n_alarms      = 0;
  int n_silenced    = 0;
  int n_arms        = 0;
  int n_full        = 0;
  int n_settings    = 1;

  function automatic bit entry_live(int i);
    return sup_valid[i] && sup_expiry[i] > ms_now;
  endfunction

  function automatic bit key_silenced(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (entry_live(i) && sup_key[i] == key)
        return 1'b1;
    return 1'b0;
  endfunction

  // same key first (even if expired), else the lowest free or expired slot
  function automatic bit arm_entry(logic [KEY_W-1:0] key, logic [HOLD_W-1:0] hold);
    int            slot;
    logic [TIME_W:0] sum;
    slot = -1;
    for (int i = 0; i < ENTRIES && slot < 0; i++)
      if (sup_valid[i] && sup_key[i] == key)
        slot = i;
    for (int i = 0; i < ENTRIES && slot < 0; i++)
      if (!entry_live(i))
        slot = i;
    if (slot < 0)
      return 1'b0;
    sum = {1'b0, ms_now} + hold;
    sup_valid[slot]  = 1'b1;
    sup_key[slot]    = key;
    sup_expiry[slot] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    return 1'b1;
  endfunction

  function automatic tas_result_t predict_alarm(cmd_t c);
    tas_result_t      r;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] warn;
    logic [VAL_W-1:0] crit;
    r    = '0;
    key  = {c.unit, c.blade, c.kind};
    warn = (c.kind == KIND_VIB) ? thr.vib_warn : thr.cav_warn;
    crit = (c.kind == KIND_VIB) ? thr.vib_crit : thr.cav_crit;
    case (c.cmd)
      CMD_CHECK: begin
        r.alarm_kind   = c.kind;
        r.alarm_unit   = c.unit;
        r.alarm_blade  = c.blade;
        r.measured_out = c.val;
        if (key_silenced(key)) begin
          r.was_suppressed = 1'b1;
        end else if ((c.kind == KIND_CAV || c.kind == KIND_VIB) && c.val >= warn) begin
          r.alarm_raised = 1'b1;
          if (c.val >= crit) begin
            r.level             = LVL_EMERGENCY;
            r.crossed_threshold = crit;
          end else begin
            r.level             = LVL_CRITICAL;
            r.crossed_threshold = warn;
          end
        end else if (c.kind == KIND_LIFE && c.val >= thr.dmg_lim) begin
          r.alarm_raised      = 1'b1;
          r.level             = LVL_CRITICAL;
          r.crossed_threshold = thr.dmg_lim;
        end
      end
      CMD_SUPPRESS: r.table_full = !arm_entry(key, c.hold);
      CMD_TICK: if (ms_now != TIME_MAX) ms_now = ms_now + 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(logic [1:0] kind);
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] c;
    w = (kind == KIND_VIB) ? thr.vib_warn : (kind == KIND_LIFE) ? thr.dmg_lim : thr.cav_warn;
    c = (kind == KIND_VIB) ? thr.vib_crit : thr.cav_crit;
    case ($urandom_range(7))
      0: return w;
      1: return w - 1'b1;
      2: return c;
      3: return c - 1'b1;
      4: return '0;
      5: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // small key pool so suppressions actually meet checks and the table fills
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   sel;
    sel   = $urandom_range(99);
    c.cmd = sel < 50 ? CMD_CHECK : sel < 75 ? CMD_SUPPRESS : sel < 95 ? CMD_TICK : CMD_SPARE;
    if ($urandom_range(9) == 0) begin
      c.unit  = 8'($urandom);
      c.blade = 8'($urandom);
    end else begin
      c.unit  = 8'($urandom_range(2));
      c.blade = 8'($urandom_range(2));
    end
    c.kind = 2'($urandom);
    if (c.cmd == CMD_CHECK && $urandom_range(9) < 3) begin
      c.unit  = armed.unit;
      c.blade = armed.blade;
      c.kind  = armed.kind;
    end
    c.val = pick_value(c.kind);
    case ($urandom_range(19))
      0: c.hold = '0;
      1: c.hold = $urandom;
      default: c.hold = HOLD_W'($urandom_range(1, 40));
    endcase
    if (c.cmd == CMD_SUPPRESS)
      armed = c;
    return c;
  endfunction

  function automatic row_t item_row(logic [1:0] cmd, logic [7:0] unit, logic [7:0] blade,
                                    logic [1:0] kind, logic [VAL_W-1:0] val,
                                    logic [HOLD_W-1:0] hold);
    row_t r;
    r         = '{what: ROW_ITEM, idx: '0, data: '0, has_exp: 1'b0, exp: '0, c: '{default: '0}};
    r.c.cmd   = cmd;
    r.c.unit  = unit;
    r.c.blade = blade;
    r.c.kind  = kind;
    r.c.val   = val;
    r.c.hold  = hold;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    row_t r;
    r = '{what: ROW_REG, idx: idx, data: data, has_exp: 1'b0, exp: '0, c: '{default: '0}};
    return r;
  endfunction

  function automatic row_t with_result(row_t r, logic raised, logic [1:0] level,
                                       logic [VAL_W-1:0] thresh, logic full);
    r.has_exp = 1'b1;
    r.exp     = '0;
    if (r.c.cmd == CMD_CHECK) begin
      r.exp.alarm_kind   = r.c.kind;
      r.exp.alarm_unit   = r.c.unit;
      r.exp.alarm_blade  = r.c.blade;
      r.exp.measured_out = r.c.val;
    end
    r.exp.alarm_raised      = raised;
    r.exp.level             = level;
    r.exp.crossed_threshold = thresh;
    r.exp.table_full        = full;
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report($sformatf("result %0d %s: expected %0d, got %0d", results_seen, name, want, got));
  endtask

  // one command transaction; returns once the block has taken it
  task automatic send(input cmd_t c, output tas_result_t pred);
    @(negedge clk);
    start           = 1'b1;
    in_cmd          = c.cmd;
    in_unit_id      = c.unit;
    in_blade_no     = c.blade;
    in_alarm_type   = c.kind;
    in_sample_value = c.val;
    in_hold_ms      = c.hold;
    do @(posedge clk); while (busy !== 1'b0);
    pred = predict_alarm(c);
    n_items++;
    if (c.cmd == CMD_CHECK)
      n_checks++;
    if (c.cmd == CMD_SUPPRESS)
      n_arms++;
    n_alarms   += pred.alarm_raised;
    n_silenced += pred.was_suppressed;
    n_full     += pred.table_full;
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start           = 1'b0;
      in_cmd          = 2'($urandom);
      in_unit_id      = 8'($urandom);
      in_blade_no     = 8'($urandom);
      in_alarm_type   = 2'($urandom);
      in_sample_value = VAL_W'($urandom);
      in_hold_ms      = $urandom;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (alarms_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    start     = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_CAV_WARN: thr.cav_warn = data;
      CFG_CAV_CRIT: thr.cav_crit = data;
      CFG_VIB_WARN: thr.vib_warn = data;
      CFG_VIB_CRIT: thr.vib_crit = data;
      CFG_DMG_LIM:  thr.dmg_lim  = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : result_check
    tas_result_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (alarms_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = alarms_due.pop_front();
        check_field("alarm_raised", want.alarm_raised, out_alarm_raised);
        check_field("level", want.level, out_alarm_level);
        check_field("alarm_kind", want.alarm_kind, out_alarm_kind);
        check_field("alarm_unit", want.alarm_unit, out_alarm_unit);
        check_field("alarm_blade", want.alarm_blade, out_alarm_blade);
        check_field("crossed_threshold", want.crossed_threshold, out_crossed_threshold);
        check_field("measured_out", want.measured_out, out_measured_out);
        check_field("was_suppressed", want.was_suppressed, out_was_suppressed);
        check_field("table_full", want.table_full, out_table_full);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT, alarms_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    row_t        rows[$];
    cmd_t        c;
    tas_result_t r;
    int          idle_pct;
    int          gap;

    thr    = '1;
    ms_now = '0;
    armed  = '{default: '0};
    for (int i = 0; i < ENTRIES; i++) begin
      sup_valid[i]  = 1'b0;
      sup_key[i]    = '0;
      sup_expiry[i] = '0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds all 65535
    rows = {rows, with_result(item_row(CMD_CHECK, 8'd0, 8'd0, KIND_CAV, 16'd0, 32'd0),
                              1'b0, LVL_WARNING, 16'd0, 1'b0)};
    rows = {rows, with_result(item_row(CMD_CHECK, 8'd255, 8'd255, KIND_VIB, 16'hFFFF, 32'd0),
                              1'b1, LVL_EMERGENCY, 16'hFFFF, 1'b0)};
    rows = {rows, with_result(item_row(CMD_CHECK, 8'd255, 8'd0, KIND_LIFE, 16'hFFFF, 32'd0),
                              1'b1, LVL_CRITICAL, 16'hFFFF, 1'b0)};
    rows = {rows, with_result(item_row(CMD_CHECK, 8'd0, 8'd255, KIND_FAULT, 16'hFFFF, '1),
                              1'b0, LVL_WARNING, 16'd0, 1'b0)};
    rows = {rows, with_result(item_row(CMD_TICK, 8'd255, 8'd255, KIND_FAULT, 16'hFFFF, '1),
                              1'b0, LVL_WARNING, 16'd0, 1'b0)};
    rows = {rows, with_result(item_row(CMD_SPARE, 8'd255, 8'd255, KIND_FAULT, 16'hFFFF, '1),
                              1'b0, LVL_WARNING, 16'd0, 1'b0)};
    rows = {rows, reg_row(CFG_CAV_WARN, 16'd1000)};
    rows = {rows, reg_row(CFG_CAV_CRIT, 16'd2000)};
    rows = {rows, reg_row(CFG_VIB_WARN, 16'd300)};
    rows = {rows, reg_row(CFG_VIB_CRIT, 16'd300)};
    rows = {rows, reg_row(CFG_DMG_LIM, 16'd0)};
    rows = {rows, reg_row(CFG_SPARE, 16'hFFFF)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_CAV, 16'd999, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_CAV, 16'd1000, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_CAV, 16'd1999, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_CAV, 16'd2000, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_VIB, 16'd300, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd1, 8'd1, KIND_LIFE, 16'd0, 32'd0)};
    // suppression: match, other kind, expiry by ticks, re-arm, zero hold, long hold
    rows = {rows, item_row(CMD_SUPPRESS, 8'd5, 8'd7, KIND_CAV, 16'd0, 32'd3)};
    rows = {rows, item_row(CMD_CHECK, 8'd5, 8'd7, KIND_CAV, 16'd5000, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd5, 8'd7, KIND_VIB, 16'd5000, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd5, 8'd7, KIND_FAULT, 16'd5000, 32'd0)};
    repeat (3) rows = {rows, item_row(CMD_TICK, 8'd0, 8'd0, KIND_CAV, 16'd0, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd5, 8'd7, KIND_CAV, 16'd5000, 32'd0)};
    rows = {rows, item_row(CMD_SUPPRESS, 8'd5, 8'd7, KIND_CAV, 16'd0, 32'd10)};
    rows = {rows, item_row(CMD_SUPPRESS, 8'd9, 8'd9, KIND_LIFE, 16'd0, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd9, 8'd9, KIND_LIFE, 16'd0, 32'd0)};
    rows = {rows, item_row(CMD_SUPPRESS, 8'd255, 8'd255, KIND_FAULT, 16'd0, '1)};
    rows = {rows, item_row(CMD_CHECK, 8'd255, 8'd255, KIND_FAULT, 16'hFFFF, 32'd0)};
    rows = {rows, item_row(CMD_CHECK, 8'd5, 8'd7, KIND_CAV, 16'd5000, 32'd0)};

    foreach (rows[i]) begin
      if (rows[i].what == ROW_REG) begin
        settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send(rows[i].c, r);
        alarms_due = {alarms_due, rows[i].has_exp ? rows[i].exp : r};
      end
    end
    n_settings++;

    // random phases: all-zero and all-ones thresholds among random settings
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: thr = '0;
        2: thr = '1;
        default: begin
          thr.cav_warn = VAL_W'($urandom);
          thr.cav_crit = VAL_W'($urandom);
          thr.vib_warn = VAL_W'($urandom);
          thr.vib_crit = VAL_W'($urandom);
          thr.dmg_lim  = VAL_W'($urandom);
        end
      endcase
      write_reg(CFG_CAV_WARN, thr.cav_warn);
      write_reg(CFG_CAV_CRIT, thr.cav_crit);
      write_reg(CFG_VIB_WARN, thr.vib_warn);
      write_reg(CFG_VIB_CRIT, thr.vib_crit);
      write_reg(CFG_DMG_LIM, thr.dmg_lim);
      n_settings++;
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 82 : 13;
      for (int n = 0; n < PER_PHASE; n++) begin
        c = random_cmd();
        send(c, r);
        alarms_due = {alarms_due, r};
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        idle_for(gap);
        // now and then hold off until the block has answered everything
        if ($urandom_range(59) == 0)
          settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    mismatches += alarms_due.size();

    $display("Ran %0d commands (%0d checks: %0d alarms, %0d silenced; %0d suppress, %0d full)",
             n_items, n_checks, n_alarms, n_silenced, n_arms, n_full);
    $display("over %0d threshold settings; %0d results compared, %0d mismatches",
             n_settings, results_seen, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
